// ===== design/rma_pkg.sv =====
// Package: shared constants, types and the arctangent table for the rotation accumulator.
`timescale 1ns / 1ps
package rma_pkg;
  localparam int ENTRY_WIDTH_DEF = 18;
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int CORDIC_STEPS    = 16;
  localparam int STEP_BITS       = 4;
  localparam int CS_SHIFT        = 30;
  localparam int CS_WIDTH        = 33;
  localparam logic signed [CS_WIDTH-1:0] GAIN_INV = 33'sd652032874;

  localparam logic [1:0] OP_X    = 2'd0;
  localparam logic [1:0] OP_Y    = 2'd1;
  localparam logic [1:0] OP_Z    = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] phase;
  } cmd_t;

  function automatic logic signed [CS_WIDTH-1:0] atan_turn(input logic [STEP_BITS-1:0] i);
    case (i)
      4'd0:  atan_turn = 33'sd536870912;
      4'd1:  atan_turn = 33'sd316933406;
      4'd2:  atan_turn = 33'sd167458907;
      4'd3:  atan_turn = 33'sd85004756;
      4'd4:  atan_turn = 33'sd42667331;
      4'd5:  atan_turn = 33'sd21354465;
      4'd6:  atan_turn = 33'sd10679838;
      4'd7:  atan_turn = 33'sd5340245;
      4'd8:  atan_turn = 33'sd2670163;
      4'd9:  atan_turn = 33'sd1335087;
      4'd10: atan_turn = 33'sd667544;
      4'd11: atan_turn = 33'sd333772;
      4'd12: atan_turn = 33'sd166886;
      4'd13: atan_turn = 33'sd83443;
      4'd14: atan_turn = 33'sd41722;
      default: atan_turn = 33'sd20861;
    endcase
  endfunction
endpackage

// ===== design/rma_stream_if.sv =====
// Interface: valid/ready channel with a generic payload.
`timescale 1ns / 1ps
interface rma_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/rma_front.sv =====
// Front end: accepts axis/angle items, forms the phase, holds a two-entry queue.
`timescale 1ns / 1ps
module rma_front #(
  parameter int ANGLE_WIDTH = rma_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic signed [ANGLE_WIDTH-1:0] in_angle,
  output logic                          q_valid,
  input  logic                          q_ready,
  output rma_pkg::cmd_t                 q_cmd
);
  import rma_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  cmd_t       incoming;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    incoming.opcode = in_opcode;
    incoming.phase  = {in_angle, {(32 - ANGLE_WIDTH){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= incoming;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== design/rma_back.sv =====
// Back end: CORDIC for cosine/sine, then one column pair at a time.
`timescale 1ns / 1ps
module rma_back #(
  parameter int ENTRY_WIDTH = rma_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  rma_pkg::cmd_t        q_cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [9*ENTRY_WIDTH-1:0] out_matrix
);
  import rma_pkg::*;

  localparam int EW = ENTRY_WIDTH;
  localparam int PW = EW + CS_WIDTH + 1;
  localparam logic signed [EW-1:0] EMAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic signed [EW-1:0] EMIN = {1'b1, {(EW-1){1'b0}}};
  localparam logic signed [EW-1:0] ONE  = {2'b01, {(EW-2){1'b0}}};

  typedef enum logic [2:0] {S_IDLE, S_CORDIC, S_MUL, S_SUM, S_OUT} state_t;

  state_t                  state;
  logic [1:0]              op;
  logic [1:0]              quad;
  logic [STEP_BITS-1:0]    step;
  logic [1:0]              col;
  logic signed [CS_WIDTH-1:0] cx, cy, cz;
  logic signed [CS_WIDTH-1:0] cc, ss;
  logic signed [EW-1:0]    m [9];
  logic signed [PW-1:0]    pa_c, pb_s, pa_s, pb_c;
  logic [31:0]             qsum;
  logic [31:0]             rbits;
  logic signed [CS_WIDTH-1:0] dx, dy;
  logic [3:0]              ip, iq;
  logic signed [EW-1:0]    ea, eb;
  logic signed [CS_WIDTH-1:0] sp;
  logic signed [PW:0]      sum_p, sum_q;
  logic signed [EW-1:0]    new_p, new_q;

  function automatic logic signed [EW-1:0] round_sat(input logic signed [PW:0] v);
    logic signed [PW:0] r;
    r = (v + (PW+1)'(1 <<< (CS_SHIFT - 1))) >>> CS_SHIFT;
    if (r > (PW+1)'(EMAX)) round_sat = EMAX;
    else if (r < (PW+1)'(EMIN)) round_sat = EMIN;
    else round_sat = r[EW-1:0];
  endfunction

  assign qsum  = q_cmd.phase + 32'h2000_0000;
  assign rbits = q_cmd.phase - {qsum[31:30], 30'd0};
  assign dx    = cy >>> step;
  assign dy    = cx >>> step;
  assign q_ready = (state == S_IDLE);

  always_comb begin
    case (op)
      OP_X: begin ip = 4'd3 + {2'd0, col}; iq = 4'd6 + {2'd0, col}; sp = ss; end
      OP_Y: begin ip = {2'd0, col}; iq = 4'd6 + {2'd0, col}; sp = ss; end
      default: begin ip = {2'd0, col}; iq = 4'd3 + {2'd0, col}; sp = -ss; end
    endcase
    ea = m[ip];
    eb = m[iq];
    sum_p = (PW+1)'(pa_c) + (PW+1)'(pb_s);
    sum_q = (PW+1)'(pb_c) - (PW+1)'(pa_s);
    new_p = round_sat(sum_p);
    new_q = round_sat(sum_q);
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      out_matrix[k*EW +: EW] = m[8 - k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        m[k] <= (k == 0 || k == 4 || k == 8) ? ONE : '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            op   <= q_cmd.opcode;
            quad <= qsum[31:30];
            cz   <= CS_WIDTH'($signed(rbits));
            cx   <= GAIN_INV;
            cy   <= '0;
            step <= '0;
            col  <= '0;
            state <= (q_cmd.opcode == OP_NONE) ? S_OUT : S_CORDIC;
            out_valid <= (q_cmd.opcode == OP_NONE);
          end
        end
        S_CORDIC: begin
          if (!cz[CS_WIDTH-1]) begin
            cx <= cx - dx; cy <= cy + dy; cz <= cz - atan_turn(step);
          end else begin
            cx <= cx + dx; cy <= cy - dy; cz <= cz + atan_turn(step);
          end
          step <= step + 1'b1;
          if (step == STEP_BITS'(CORDIC_STEPS - 1)) state <= S_MUL;
        end
        S_MUL: begin
          if (col == 2'd0 && step == '0) begin
            // quadrant fold once, before the first column
            case (quad)
              2'd0: begin cc <= cx;  ss <= cy;  end
              2'd1: begin cc <= -cy; ss <= cx;  end
              2'd2: begin cc <= -cx; ss <= -cy; end
              default: begin cc <= cy; ss <= -cx; end
            endcase
            step <= 4'd1;
          end else begin
            pa_c <= PW'(ea) * PW'(cc);
            pb_s <= PW'(eb) * PW'(sp);
            pa_s <= PW'(ea) * PW'(sp);
            pb_c <= PW'(eb) * PW'(cc);
            state <= S_SUM;
          end
        end
        S_SUM: begin
          m[ip] <= new_p;
          m[iq] <= new_q;
          if (col == 2'd2) begin
            state <= S_OUT;
            out_valid <= 1'b1;
          end else begin
            col <= col + 1'b1;
            state <= S_MUL;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/rotation_matrix_accumulator.sv =====
// Top level: rotation matrix accumulator, front queue plus CORDIC/mix back end.
//   channel | dir | payload
//   in_ch   | in  | opcode[1:0], angle[ANGLE_WIDTH-1:0]
//   out_ch  | out | m00..m22, ENTRY_WIDTH each
// An item goes through dispatch, 16 CORDIC iterations, one quadrant fold and a
// multiply and a round step for each of the 3 columns, then the output state.
// Opcode three goes straight from dispatch to output.
// The back end works on one item at a time; that sets the rate.
// rst is synchronous; it empties the queue and loads the identity matrix.
// A stalled result holds the back end; the front queue takes up to two more items.
`timescale 1ns / 1ps
module rotation_matrix_accumulator #(
  parameter int ENTRY_WIDTH = rma_pkg::ENTRY_WIDTH_DEF,
  parameter int ANGLE_WIDTH = rma_pkg::ANGLE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  rma_stream_if.sink   in_ch,
  rma_stream_if.source out_ch
);
  import rma_pkg::*;

  logic                   q_valid;
  logic                   q_ready;
  cmd_t                   q_cmd;
  logic [9*ENTRY_WIDTH-1:0] matrix;

  rma_front #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_opcode(in_ch.data.opcode), .in_angle(in_ch.data.angle),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  rma_back #(.ENTRY_WIDTH(ENTRY_WIDTH)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_matrix(matrix)
  );

  assign out_ch.data = matrix;
endmodule

// ===== tb/rotation_matrix_accumulator_tb.sv =====
// Testbench: checks the rotation accumulator's nine entries against a fixed-point predictor.
`timescale 1ns / 1ps
module rotation_matrix_accumulator_tb;
  import rma_pkg::*;

  localparam int EW = ENTRY_WIDTH_DEF;
  localparam int AW = ANGLE_WIDTH_DEF;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [1:0]    opcode;
    logic [AW-1:0] angle;
  } rot_cmd_t;

  typedef struct packed {
    logic [EW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } orient_t;

  class orientation_board;
    longint orient[9];
    orient_t pending[$];
    int errors;

    function new();
      orient = '{65536, 0, 0, 0, 65536, 0, 0, 0, 65536};
      errors = 0;
    endfunction

    function void cordic(input logic [AW-1:0] ang, output longint c, output longint s);
      logic [31:0] phase, rbits;
      logic [1:0] quad;
      longint x, y, z, dx, dy;
      phase = {ang, {(32 - AW){1'b0}}};
      quad = 2'((phase + 32'h2000_0000) >> 30);
      rbits = phase - ({30'd0, quad} << 30);
      z = longint'($signed(rbits));
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(atan_val(i));
        end else begin
          x += dx; y -= dy; z += longint'(atan_val(i));
        end
      end
      case (quad)
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function longint atan_val(input int i);
      longint tbl[16];
      tbl = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
              10679838, 5340245, 2670163, 1335087, 667544, 333772,
              166886, 83443, 41722, 20861};
      return tbl[i];
    endfunction

    function longint blend(input longint a, b, ca, cb);
      longint r;
      r = (a * ca + b * cb + (64'sd1 <<< 29)) >>> 30;
      if (r > 131071) r = 131071;
      if (r < -131072) r = -131072;
      return r;
    endfunction

    function void note_rotation(input rot_cmd_t cmd);
      longint c, s, sp, a, b;
      int p, q;
      orient_t res;
      logic [EW-1:0] ent[9];
      if (cmd.opcode != OP_NONE) begin
        cordic(cmd.angle, c, s);
        if (cmd.opcode == OP_X) begin p = 1; q = 2; sp = s; end
        else if (cmd.opcode == OP_Y) begin p = 0; q = 2; sp = s; end
        else begin p = 0; q = 1; sp = -s; end
        for (int k = 0; k < 3; k++) begin
          a = orient[p*3+k];
          b = orient[q*3+k];
          orient[p*3+k] = blend(a, b, c, sp);
          orient[q*3+k] = blend(a, b, -sp, c);
        end
      end
      for (int k = 0; k < 9; k++) ent[k] = EW'(orient[k]);
      res = {ent[0], ent[1], ent[2], ent[3], ent[4], ent[5], ent[6], ent[7], ent[8]};
      pending.push_back(res);
    endfunction

    function void check_matrix(input orient_t got);
      orient_t want;
      logic [9*EW-1:0] wv, gv;
      logic [EW-1:0] we, ge;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      wv = want;
      gv = got;
      for (int k = 0; k < 9; k++) begin
        we = wv[(8-k)*EW +: EW];
        ge = gv[(8-k)*EW +: EW];
        if (we !== ge) begin
          errors++;
          if (errors <= 10)
            $display("entry m%0d%0d: expected %0d, got %0d", k / 3, k % 3,
                     $signed(we), $signed(ge));
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  orientation_board board = new();

  rma_stream_if #(.payload_t(rot_cmd_t)) in_ch (clk);
  rma_stream_if #(.payload_t(orient_t))  out_ch (clk);

  rotation_matrix_accumulator dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // receiver: random stalls per phase
  always @(negedge clk)
    out_ch.ready <= !rst && ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) board.note_rotation(in_ch.data);
      if (out_ch.valid && out_ch.ready) board.check_matrix(out_ch.data);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("rotation_matrix_accumulator: mismatch");
        $finish;
      end
    end
  end

  task automatic send_rotation(input logic [1:0] op, input logic [AW-1:0] ang);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.data = '{opcode: op, angle: ang};
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic random_phase(input int idle, input int stall, input int count);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int n = 0; n < count; n++)
      send_rotation(2'($urandom_range(3)), AW'($urandom));
  endtask

  initial begin
    logic [AW-1:0] corner[8];
    corner = '{16'h0000, 16'h4000, 16'h8000, 16'h7fff, 16'hffff, 16'h0001,
               16'h2000, 16'he000};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // directed: every axis over seven of the eight quadrant-edge and extreme angles, then two no-ops
    for (int op = 0; op < 3; op++)
      for (int k = 0; k < 7; k++) send_rotation(2'(op), corner[(k + op) % 8]);
    send_rotation(OP_NONE, 16'h1234);
    send_rotation(OP_NONE, 16'h8000);
    random_phase(0, 0, 300);
    random_phase(57, 0, 300);
    random_phase(0, 57, 300);
    random_phase(35, 35, 300);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0)
      $display("rotation_matrix_accumulator: match");
    else
      $display("rotation_matrix_accumulator: mismatch");
    $finish;
  end
endmodule
